[design/pwf_pkg.sv]
// Package for the process whitelist packet filter.
// Holds field widths, operation codes, controller states and command/status structs.
// No dependencies.
`default_nettype none

package pwf_pkg;

    localparam int UID_W       = 32;
    localparam int PID_W       = 22;
    localparam int OP_W        = 2;
    localparam int ENTRIES_DEF = 16;

    // Input word layout, lowest bit first
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the accepted word, restart the scan
        logic step;    // advance the table scan
        logic commit;  // apply table update, hand result to output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic op_clear;
    } t_sts;

endpackage

`default_nettype wire

[design/pwf_ctrl.sv]
// Controller state machine of the process whitelist packet filter.
// Depends on pwf_pkg; drives pwf_dp through t_cmd and reads t_sts.
`default_nettype none

module pwf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_out_free,
    input  wire pwf_pkg::t_sts i_sts,
    output pwf_pkg::t_cmd      o_cmd,
    output logic               o_s_tready
);

    pwf_pkg::t_state r_state;
    pwf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pwf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            pwf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pwf_pkg::ST_SCAN;
                end
            end
            pwf_pkg::ST_SCAN: begin
                o_cmd.step = 1'b1;
                // clear needs no table contents
                if (i_sts.scan_done || i_sts.op_clear) begin
                    n_state = pwf_pkg::ST_DONE;
                end
            end
            pwf_pkg::ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = pwf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pwf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/pwf_dp.sv]
// Datapath of the process whitelist packet filter: entry memory, valid bits,
// scan compare, special user register and result logic. Depends on pwf_pkg.
`default_nettype none

module pwf_dp #(
    parameter int ENTRIES = pwf_pkg::ENTRIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire pwf_pkg::t_cmd             i_cmd,
    input  wire logic [pwf_pkg::OP_W-1:0]  i_op,
    input  wire logic [pwf_pkg::UID_W-1:0] i_uid,
    input  wire logic [pwf_pkg::PID_W-1:0] i_pid,
    input  wire logic                      i_cfg_valid,
    input  wire logic [pwf_pkg::UID_W-1:0] i_cfg_data,
    output pwf_pkg::t_sts                  o_sts,
    output logic                           o_accept,
    output logic                           o_status
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CW-1:0] SCAN_END = CW'(ENTRIES);

    // latched word
    logic [pwf_pkg::OP_W-1:0]  r_op;
    logic [pwf_pkg::UID_W-1:0] r_uid;
    logic [pwf_pkg::PID_W-1:0] r_pid;

    logic [pwf_pkg::UID_W-1:0] r_special_uid;
    logic [ENTRIES-1:0]        r_valid;

    logic [pwf_pkg::UID_W-1:0] mem_user [ENTRIES];
    logic [pwf_pkg::PID_W-1:0] mem_proc [ENTRIES];

    logic [CW-1:0]             r_rd_cnt;
    logic                      r_cmp_vld;
    logic [IW-1:0]             r_cmp_idx;
    logic [pwf_pkg::UID_W-1:0] r_rd_user;
    logic [pwf_pkg::PID_W-1:0] r_rd_proc;

    logic          r_hit;
    logic          r_pid_found;
    logic [IW-1:0] r_pid_slot;
    logic          r_free_found;
    logic [IW-1:0] r_free_slot;

    logic w_rd_en;
    logic w_wr_en;
    logic w_ent_valid;
    logic w_user_eq;
    logic w_proc_eq;
    logic w_hit_now;
    logic w_pid_now;

    assign w_rd_en = i_cmd.step && (r_rd_cnt != SCAN_END);
    assign w_wr_en = i_cmd.commit && (r_op == pwf_pkg::OP_ADD)
                     && !r_pid_found && r_free_found;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_user[r_free_slot] <= r_uid;
            mem_proc[r_free_slot] <= r_pid;
        end
        if (w_rd_en) begin
            r_rd_user <= mem_user[r_rd_cnt[IW-1:0]];
            r_rd_proc <= mem_proc[r_rd_cnt[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_uid <= i_uid;
            r_pid <= i_pid;
        end
        if (w_rd_en) begin
            r_cmp_idx <= r_rd_cnt[IW-1:0];
        end
    end

    // entry compare
    assign w_ent_valid = r_valid[r_cmp_idx];
    assign w_user_eq   = (r_rd_user == r_uid);
    assign w_proc_eq   = (r_rd_proc == r_pid);
    assign w_hit_now   = w_ent_valid && w_user_eq
                         && ((r_rd_user != r_special_uid) || w_proc_eq);
    assign w_pid_now   = w_ent_valid && w_proc_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_special_uid <= '0;
            r_valid       <= '0;
            r_rd_cnt      <= '0;
            r_cmp_vld     <= 1'b0;
            r_hit         <= 1'b0;
            r_pid_found   <= 1'b0;
            r_pid_slot    <= '0;
            r_free_found  <= 1'b0;
            r_free_slot   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_special_uid <= i_cfg_data;
            end

            if (i_cmd.load) begin
                r_rd_cnt     <= '0;
                r_cmp_vld    <= 1'b0;
                r_hit        <= 1'b0;
                r_pid_found  <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                r_cmp_vld <= w_rd_en;
                if (w_rd_en) begin
                    r_rd_cnt <= r_rd_cnt + CW'(1);
                end
                if (r_cmp_vld) begin
                    if (w_hit_now) begin
                        r_hit <= 1'b1;
                    end
                    if (w_pid_now && !r_pid_found) begin
                        r_pid_found <= 1'b1;
                        r_pid_slot  <= r_cmp_idx;
                    end
                    // lowest free slot
                    if (!w_ent_valid && !r_free_found) begin
                        r_free_found <= 1'b1;
                        r_free_slot  <= r_cmp_idx;
                    end
                end
            end

            if (i_cmd.commit) begin
                case (r_op)
                    pwf_pkg::OP_ADD: begin
                        if (w_wr_en) begin
                            r_valid[r_free_slot] <= 1'b1;
                        end
                    end
                    pwf_pkg::OP_DELETE: begin
                        if (r_pid_found) begin
                            r_valid[r_pid_slot] <= 1'b0;
                        end
                    end
                    pwf_pkg::OP_CLEAR: begin
                        r_valid <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_sts.scan_done = (r_rd_cnt == SCAN_END) && !r_cmp_vld;
    assign o_sts.op_clear  = (r_op == pwf_pkg::OP_CLEAR);

    assign o_accept = (r_op == pwf_pkg::OP_LOOKUP) && r_hit;
    assign o_status = (r_op == pwf_pkg::OP_ADD) && !r_pid_found && !r_free_found;

endmodule

`default_nettype wire

[design/process_whitelist_packet_filter_top.sv]
// Top level of the process whitelist packet filter.
// Depends on pwf_pkg, pwf_ctrl and pwf_dp; holds the output word register.
`default_nettype none

// The filter keeps a whitelist of up to ENTRIES (user id, process id) pairs and
// takes one word at a time: lookup, add, delete by process id, or clear. Every
// word yields one result word. A lookup passes (accept = 1) when a valid entry
// has the packet's user id and that user id is not special_uid, or the entry's
// process id matches as well; an empty table drops. An add of a process id
// already present changes nothing; an add into a full table reports status 1
// and fills nothing, otherwise the lowest free slot is taken. Timing: a word
// is taken, then the entry memory is scanned one entry per cycle through its
// single registered read port (a clear does not wait for the scan), then the
// commit applies the update and loads the output register, waiting while the
// output register is full and not being taken. The next word is taken while
// the result still waits in the output register. special_uid is written over
// the cfg channel, which is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this.

module process_whitelist_packet_filter_top #(
    parameter int ENTRIES = pwf_pkg::ENTRIES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // slave word: op [1:0], uid [33:2], pid [55:34]
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [pwf_pkg::S_DATA_W-1:0] s_tdata,
    // master word: accept [0], status [1], zero [7:2]
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [pwf_pkg::M_DATA_W-1:0]      m_tdata,
    // special_uid write
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [pwf_pkg::UID_W-1:0]    i_cfg_data
);

    localparam int UID_LO = pwf_pkg::OP_W;
    localparam int PID_LO = pwf_pkg::OP_W + pwf_pkg::UID_W;

    pwf_pkg::t_cmd w_cmd;
    pwf_pkg::t_sts w_sts;
    logic          w_out_free;
    logic          w_accept;
    logic          w_status;

    logic                        r_m_valid;
    logic [pwf_pkg::M_DATA_W-1:0] r_m_data;

    assign o_cfg_ready = 1'b1;

    // result register may be reloaded in the cycle it is taken
    assign w_out_free = !r_m_valid || m_tready;

    pwf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_s_tready (s_tready)
    );

    pwf_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_op        (s_tdata[pwf_pkg::OP_W-1:0]),
        .i_uid       (s_tdata[UID_LO +: pwf_pkg::UID_W]),
        .i_pid       (s_tdata[PID_LO +: pwf_pkg::PID_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_sts       (w_sts),
        .o_accept    (w_accept),
        .o_status    (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_m_data <= {{(pwf_pkg::M_DATA_W - 2){1'b0}}, w_status, w_accept};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

`default_nettype wire
